// ----- hdl/dfma_pkg.sv -----
// Package of types, constants and helper functions for the binary64 fused multiply-add.
`default_nettype none
package dfma_pkg;

    typedef logic signed [13:0] exp_t;

    typedef struct packed {
        logic [52:0] mant;
        exp_t        ex;
    } norm_t;

    localparam logic [63:0] QUIET_BIT   = 64'h0008_0000_0000_0000;
    localparam logic [63:0] DEFAULT_NAN = 64'h7FF8_0000_0000_0000;
    localparam logic [63:0] INF_BITS    = 64'h7FF0_0000_0000_0000;
    localparam exp_t        EXP_MIN     = -14'sd1074;
    localparam exp_t        EXP_BIAS    = 14'sd1075;
    localparam exp_t        EXP_FIELD   = 14'sd1074;
    localparam exp_t        MANT_TOP    = 14'sd52;
    localparam exp_t        ADD_SHIFT   = 14'sd73;
    localparam exp_t        WIN_GUARD   = 14'sd75;
    localparam exp_t        EXP_LIMIT   = 14'sd2047;

    function automatic logic [5:0] lzc53(input logic [52:0] v);
        logic [5:0] n;
        n = 6'd0;
        for (int i = 0; i < 53; i++)
        begin
            if (v[i])
            begin
                n = 6'(52 - i);
            end
        end
        return n;
    endfunction

    function automatic logic [6:0] msb128(input logic [127:0] v);
        logic [6:0] n;
        n = 7'd0;
        for (int i = 0; i < 128; i++)
        begin
            if (v[i])
            begin
                n = 7'(i);
            end
        end
        return n;
    endfunction

    function automatic norm_t normalise(input logic [63:0] v);
        norm_t      r;
        logic [5:0] lz;
        r.mant = {v[62:52] != 11'd0, v[51:0]};
        lz     = lzc53(r.mant);
        r.mant = r.mant << lz;
        r.ex   = ((v[62:52] == 11'd0) ? EXP_MIN : (exp_t'({3'b000, v[62:52]}) - EXP_BIAS))
                 - exp_t'({8'd0, lz});
        return r;
    endfunction

    function automatic logic [127:0] shr_jam(input logic [127:0] x, input logic [7:0] n);
        logic [127:0] r;
        logic [127:0] mask;
        if (n[7])
        begin
            r = {127'd0, |x};
        end
        else
        begin
            mask = ~({128{1'b1}} << n[6:0]);
            r    = x >> n[6:0];
            r[0] = r[0] | (|(x & mask));
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/dfma_in_if.sv -----
// Interface of the operand channel: three binary64 words with valid and ready.
`default_nettype none
interface dfma_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] mul_a;
    logic [63:0] mul_b;
    logic [63:0] addend;

    modport source (output valid, output mul_a, output mul_b, output addend, input ready);
    modport sink (input valid, input mul_a, input mul_b, input addend, output ready);
endinterface
`default_nettype wire

// ----- hdl/dfma_out_if.sv -----
// Interface of the result channel: one binary64 word with valid and ready.
`default_nettype none
interface dfma_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] fused_sum;

    modport source (output valid, output fused_sum, input ready);
    modport sink (input valid, input fused_sum, output ready);
endinterface
`default_nettype wire

// ----- hdl/double_fused_multiply_add.sv -----
// Top level of the pipelined binary64 fused multiply-add, rounded to nearest even.
//
//   channel   direction   word
//   in_ch     sink        mul_a, mul_b, addend (binary64 bit patterns)
//   out_ch    source      fused_sum (binary64 bit pattern)
//
// Eight register stages; one word enters per cycle while out_ch does not stall.
// The rate is set by the stage chain as a whole, each stage holding one wide step.
// Reset clears the stage valid bits only; the datapath registers hold no reset value.
// When out_ch stalls the whole pipeline holds, so no word is lost or repeated.
`default_nettype none
module double_fused_multiply_add
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    dfma_in_if.sink       in_ch,
    dfma_out_if.source    out_ch
);
    import dfma_pkg::*;

    logic [7:0] valid_reg;
    logic       en;

    assign en           = !valid_reg[7] || out_ch.ready;
    assign in_ch.ready  = en;
    assign out_ch.valid = valid_reg[7];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 8'd0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[6:0], in_ch.valid};
        end
    end

    // Stage one: special operands and normalised mantissas.
    logic [63:0] a, b, c;
    logic        sp, sc;
    logic        nan_a, nan_b, nan_c, inf_a, inf_b, inf_c, zero_a, zero_b, zero_c;
    logic        spec_next;
    logic [63:0] sval_next;
    norm_t       na, nb, nc;

    assign a = in_ch.mul_a;
    assign b = in_ch.mul_b;
    assign c = in_ch.addend;

    always_comb
    begin
        sp     = a[63] ^ b[63];
        sc     = c[63];
        nan_a  = (a[62:52] == 11'h7FF) && (a[51:0] != 52'd0);
        nan_b  = (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
        nan_c  = (c[62:52] == 11'h7FF) && (c[51:0] != 52'd0);
        inf_a  = (a[62:0] == INF_BITS[62:0]);
        inf_b  = (b[62:0] == INF_BITS[62:0]);
        inf_c  = (c[62:0] == INF_BITS[62:0]);
        zero_a = (a[62:0] == 63'd0);
        zero_b = (b[62:0] == 63'd0);
        zero_c = (c[62:0] == 63'd0);
        spec_next = 1'b1;
        sval_next = 64'd0;
        if (nan_a)
        begin
            sval_next = a | QUIET_BIT;
        end
        else if (nan_b)
        begin
            sval_next = b | QUIET_BIT;
        end
        else if (nan_c)
        begin
            sval_next = c | QUIET_BIT;
        end
        else if (inf_a || inf_b)
        begin
            if (zero_a || zero_b)
            begin
                sval_next = DEFAULT_NAN;
            end
            else if (inf_c && (sc != sp))
            begin
                sval_next = DEFAULT_NAN;
            end
            else
            begin
                sval_next = INF_BITS | {sp, 63'd0};
            end
        end
        else if (inf_c)
        begin
            sval_next = c;
        end
        else if (zero_a || zero_b)
        begin
            sval_next = zero_c ? {sp & sc, 63'd0} : c;
        end
        else
        begin
            spec_next = 1'b0;
        end
        na = normalise(a);
        nb = normalise(b);
        nc = normalise(c);
    end

    logic [52:0] s1_ma_reg, s1_mb_reg, s1_mc_reg;
    exp_t        s1_ea_reg, s1_eb_reg, s1_ec_reg;
    logic        s1_sp_reg, s1_sc_reg, s1_cz_reg, s1_spec_reg;
    logic [63:0] s1_sval_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_ma_reg   <= na.mant;
            s1_mb_reg   <= nb.mant;
            s1_mc_reg   <= nc.mant;
            s1_ea_reg   <= na.ex;
            s1_eb_reg   <= nb.ex;
            s1_ec_reg   <= nc.ex;
            s1_sp_reg   <= sp;
            s1_sc_reg   <= sc;
            s1_cz_reg   <= zero_c;
            s1_spec_reg <= spec_next;
            s1_sval_reg <= sval_next;
        end
    end

    // Stage two: four partial products of the mantissas.
    logic [53:0] s2_hh_reg;
    logic [52:0] s2_hl_reg, s2_lh_reg;
    logic [51:0] s2_ll_reg;
    exp_t        s2_eab_reg, s2_ec_reg;
    logic [52:0] s2_mc_reg;
    logic        s2_sp_reg, s2_sc_reg, s2_cz_reg, s2_spec_reg;
    logic [63:0] s2_sval_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_hh_reg   <= s1_ma_reg[52:26] * s1_mb_reg[52:26];
            s2_hl_reg   <= s1_ma_reg[52:26] * s1_mb_reg[25:0];
            s2_lh_reg   <= s1_ma_reg[25:0] * s1_mb_reg[52:26];
            s2_ll_reg   <= s1_ma_reg[25:0] * s1_mb_reg[25:0];
            s2_eab_reg  <= s1_ea_reg + s1_eb_reg;
            s2_ec_reg   <= s1_ec_reg - ADD_SHIFT;
            s2_mc_reg   <= s1_mc_reg;
            s2_sp_reg   <= s1_sp_reg;
            s2_sc_reg   <= s1_sc_reg;
            s2_cz_reg   <= s1_cz_reg;
            s2_spec_reg <= s1_spec_reg;
            s2_sval_reg <= s1_sval_reg;
        end
    end

    // Stage three: full product, placement in the window and exponent difference.
    logic [105:0] prod;
    logic [127:0] pw, cw;
    exp_t         ep, diff, el3;
    logic         pf;
    logic [7:0]   dsat;

    always_comb
    begin
        prod = {s2_hh_reg, 52'd0} + {27'd0, s2_hl_reg, 26'd0}
               + {27'd0, s2_lh_reg, 26'd0} + {54'd0, s2_ll_reg};
        if (prod[105])
        begin
            pw = {2'b00, prod, 20'd0};
            ep = s2_eab_reg - 14'sd20;
        end
        else
        begin
            pw = {2'b00, prod[104:0], 21'd0};
            ep = s2_eab_reg - 14'sd21;
        end
        cw   = s2_cz_reg ? 128'd0 : {2'b00, s2_mc_reg, 73'd0};
        pf   = s2_cz_reg || (ep >= s2_ec_reg);
        diff = pf ? (ep - s2_ec_reg) : (s2_ec_reg - ep);
        el3  = pf ? ep : s2_ec_reg;
        if (s2_cz_reg)
        begin
            dsat = 8'd0;
        end
        else if (diff >= 14'sd128)
        begin
            dsat = 8'd128;
        end
        else
        begin
            dsat = diff[7:0];
        end
    end

    logic [127:0] s3_p_reg, s3_c_reg;
    logic         s3_pf_reg;
    logic [7:0]   s3_d_reg;
    exp_t         s3_el_reg;
    logic         s3_sp_reg, s3_sc_reg, s3_spec_reg;
    logic [63:0]  s3_sval_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_p_reg    <= pw;
            s3_c_reg    <= cw;
            s3_pf_reg   <= pf;
            s3_d_reg    <= dsat;
            s3_el_reg   <= el3;
            s3_sp_reg   <= s2_sp_reg;
            s3_sc_reg   <= s2_sc_reg;
            s3_spec_reg <= s2_spec_reg;
            s3_sval_reg <= s2_sval_reg;
        end
    end

    // Stage four: alignment of the smaller operand with a sticky bit.
    logic [127:0] shifted;

    assign shifted = shr_jam(s3_pf_reg ? s3_c_reg : s3_p_reg, s3_d_reg);

    logic [127:0] s4_p_reg, s4_c_reg;
    exp_t         s4_el_reg;
    logic         s4_sp_reg, s4_sc_reg, s4_spec_reg;
    logic [63:0]  s4_sval_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_p_reg    <= s3_pf_reg ? s3_p_reg : shifted;
            s4_c_reg    <= s3_pf_reg ? shifted : s3_c_reg;
            s4_el_reg   <= s3_el_reg;
            s4_sp_reg   <= s3_sp_reg;
            s4_sc_reg   <= s3_sc_reg;
            s4_spec_reg <= s3_spec_reg;
            s4_sval_reg <= s3_sval_reg;
        end
    end

    // Stage five: signed magnitude addition.
    logic [127:0] sum5;
    logic         sr5, zero5, p_big;

    always_comb
    begin
        p_big = (s4_p_reg >= s4_c_reg);
        if (s4_sp_reg == s4_sc_reg)
        begin
            sum5  = s4_p_reg + s4_c_reg;
            sr5   = s4_sp_reg;
            zero5 = 1'b0;
        end
        else
        begin
            sum5  = p_big ? (s4_p_reg - s4_c_reg) : (s4_c_reg - s4_p_reg);
            sr5   = p_big ? s4_sp_reg : s4_sc_reg;
            zero5 = (sum5 == 128'd0);
        end
    end

    logic [127:0] s5_r_reg;
    exp_t         s5_el_reg;
    logic         s5_sr_reg, s5_zero_reg, s5_spec_reg;
    logic [63:0]  s5_sval_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_r_reg    <= sum5;
            s5_el_reg   <= s4_el_reg;
            s5_sr_reg   <= sr5;
            s5_zero_reg <= zero5;
            s5_spec_reg <= s4_spec_reg;
            s5_sval_reg <= s4_sval_reg;
        end
    end

    // Stage six: leading one, result exponent and normalising shift amount.
    exp_t etop, lsb6, t6;

    always_comb
    begin
        etop = s5_el_reg + exp_t'({7'd0, msb128(s5_r_reg)});
        lsb6 = ((etop - MANT_TOP) < EXP_MIN) ? EXP_MIN : (etop - MANT_TOP);
        t6   = s5_el_reg + WIN_GUARD - lsb6;
    end

    logic [127:0] s6_r_reg;
    exp_t         s6_lsb_reg, s6_t_reg;
    logic         s6_sr_reg, s6_zero_reg, s6_spec_reg;
    logic [63:0]  s6_sval_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s6_r_reg    <= s5_r_reg;
            s6_lsb_reg  <= lsb6;
            s6_t_reg    <= t6;
            s6_sr_reg   <= s5_sr_reg;
            s6_zero_reg <= s5_zero_reg;
            s6_spec_reg <= s5_spec_reg;
            s6_sval_reg <= s5_sval_reg;
        end
    end

    // Stage seven: shift so that the kept mantissa sits at the top of the window.
    logic [127:0] w7;
    exp_t         nt;

    always_comb
    begin
        nt = -s6_t_reg;
        if (!s6_t_reg[13])
        begin
            w7 = s6_r_reg << s6_t_reg[6:0];
        end
        else if (nt >= 14'sd128)
        begin
            w7 = shr_jam(s6_r_reg, 8'd128);
        end
        else
        begin
            w7 = shr_jam(s6_r_reg, nt[7:0]);
        end
    end

    logic [127:0] s7_w_reg;
    exp_t         s7_lsb_reg;
    logic         s7_sr_reg, s7_zero_reg, s7_spec_reg;
    logic [63:0]  s7_sval_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s7_w_reg    <= w7;
            s7_lsb_reg  <= s6_lsb_reg;
            s7_sr_reg   <= s6_sr_reg;
            s7_zero_reg <= s6_zero_reg;
            s7_spec_reg <= s6_spec_reg;
            s7_sval_reg <= s6_sval_reg;
        end
    end

    // Stage eight: rounding to nearest even, packing and overflow.
    logic [53:0] q1;
    logic        inc;
    exp_t        bexp, field;
    logic [63:0] packed_val, result_next;

    always_comb
    begin
        inc   = s7_w_reg[74] && ((|s7_w_reg[73:0]) || s7_w_reg[75]);
        q1    = {1'b0, s7_w_reg[127:75]} + {53'd0, inc};
        bexp  = s7_lsb_reg + EXP_FIELD;
        field = bexp + exp_t'({12'd0, q1[53:52]});
        packed_val = {1'b0, bexp[10:0], 52'd0} + {10'd0, q1};
        if (s7_spec_reg)
        begin
            result_next = s7_sval_reg;
        end
        else if (s7_zero_reg)
        begin
            result_next = 64'd0;
        end
        else if (field >= EXP_LIMIT)
        begin
            result_next = INF_BITS | {s7_sr_reg, 63'd0};
        end
        else
        begin
            result_next = {s7_sr_reg, packed_val[62:0]};
        end
    end

    logic [63:0] out_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= result_next;
        end
    end

    assign out_ch.fused_sum = out_reg;

endmodule
`default_nettype wire
